@@ rtl/core/ced_pkg.sv @@
// types, constants and helper functions shared by the escape decoder
`timescale 1ns / 1ps

package ced_pkg;

   // decoder mode, all four codes are in use
   typedef enum logic [1:0] {
      MODE_NORMAL = 2'd0,
      MODE_ESCAPE = 2'd1,
      MODE_HEX    = 2'd2,
      MODE_OCT    = 2'd3
   } ced_mode_type;

   // kind of hex escape
   typedef enum logic [1:0] {
      KIND_X  = 2'd0,
      KIND_U4 = 2'd1,
      KIND_U8 = 2'd2
   } ced_kind_type;

   localparam logic [7:0] CH_BSLASH  = 8'h5C;
   localparam logic [7:0] CH_NEWLINE = 8'h0A;
   localparam logic [7:0] CH_LOW_X   = 8'h78;
   localparam logic [7:0] CH_LOW_U   = 8'h75;
   localparam logic [7:0] CH_UP_U    = 8'h55;
   localparam logic [7:0] CH_ZERO    = 8'h30;
   localparam logic [7:0] CH_SEVEN   = 8'h37;
   localparam logic [7:0] CH_NINE    = 8'h39;
   localparam logic [7:0] CH_LOW_A   = 8'h61;
   localparam logic [7:0] CH_LOW_F   = 8'h66;
   localparam logic [7:0] CH_UP_A    = 8'h41;
   localparam logic [7:0] CH_UP_F    = 8'h46;
   localparam logic [7:0] CH_QUESTION = 8'h3F;

   localparam logic [3:0] OCT_LIMIT = 4'd3;

   // queue between front and back
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   // all bytes caused by one input beat
   typedef struct packed {
      logic [3:0][7:0] data;
      logic [1:0]      last_idx;
      logic            marker;    // empty end-of-text result
      logic            text_end;
   } ced_bundle_type;

   typedef struct packed {
      logic not_empty;
      logic full;
   } ced_q_status_type;

   typedef struct packed {
      logic [2:0][7:0] data;
      logic [1:0]      count;     // 1 to 3
   } ced_enc_type;

   typedef struct packed {
      logic       ok;
      logic [3:0] value;
   } ced_hex_type;

   function automatic logic [7:0] map_control(input logic [7:0] c);
      logic [7:0] r;
      unique case (c)
         8'h61:   r = 8'h07;  // a
         8'h62:   r = 8'h08;  // b
         8'h66:   r = 8'h0C;  // f
         8'h6E:   r = 8'h0A;  // n
         8'h72:   r = 8'h0D;  // r
         8'h74:   r = 8'h09;  // t
         8'h76:   r = 8'h0B;  // v
         default: r = c;
      endcase
      return r;
   endfunction

   function automatic ced_hex_type hex_digit(input logic [7:0] c);
      ced_hex_type h;
      h.ok    = 1'b0;
      h.value = 4'd0;
      if (c >= CH_ZERO && c <= CH_NINE) begin
         h.ok    = 1'b1;
         h.value = c[3:0];
      end else if ((c >= CH_LOW_A && c <= CH_LOW_F) || (c >= CH_UP_A && c <= CH_UP_F)) begin
         h.ok    = 1'b1;
         h.value = c[3:0] + 4'd9;
      end
      return h;
   endfunction

   function automatic logic [3:0] hex_limit(input ced_kind_type k);
      logic [3:0] r;
      unique case (k)
         KIND_U4: r = 4'd4;
         KIND_U8: r = 4'd8;
         default: r = 4'd2;
      endcase
      return r;
   endfunction

   // 16-bit code point to utf-8, surrogates become '?'
   function automatic ced_enc_type utf8_encode(input logic [15:0] v);
      ced_enc_type e;
      e.data = '0;
      if (v[15:7] == 9'd0) begin
         e.data[0] = v[7:0];
         e.count   = 2'd1;
      end else if (v[15:11] == 5'd0) begin
         e.data[0] = {3'b110, v[10:6]};
         e.data[1] = {2'b10, v[5:0]};
         e.count   = 2'd2;
      end else if (v[15:11] == 5'b11011) begin
         e.data[0] = CH_QUESTION;
         e.count   = 2'd1;
      end else begin
         e.data[0] = {4'b1110, v[15:12]};
         e.data[1] = {2'b10, v[11:6]};
         e.data[2] = {2'b10, v[5:0]};
         e.count   = 2'd3;
      end
      return e;
   endfunction

endpackage

@@ rtl/core/ced_req_if.sv @@
// input channel: source text bytes
`timescale 1ns / 1ps

interface ced_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] in_byte;
   logic       end_of_text;

   modport source (output valid, output in_byte, output end_of_text, input ready);
   modport sink   (input valid, input in_byte, input end_of_text, output ready);
endinterface

@@ rtl/core/ced_rsp_if.sv @@
// result channel: decoded bytes
`timescale 1ns / 1ps

interface ced_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_byte;
   logic       byte_valid;
   logic       run_last;
   logic       text_done;

   modport source (output valid, output out_byte, output byte_valid, output run_last,
                   output text_done, input ready);
   modport sink   (input valid, input out_byte, input byte_valid, input run_last,
                   input text_done, output ready);
endinterface

@@ rtl/core/ced_front.sv @@
// front end: escape state machine, one input beat to at most one bundle of bytes
`timescale 1ns / 1ps

module ced_front (
   input  logic                      clock,
   input  logic                      reset,
   ced_req_if.sink                   req_chan,
   input  ced_pkg::ced_q_status_type q_status,
   output logic                      push,
   output ced_pkg::ced_bundle_type   push_data
);

   ced_pkg::ced_mode_type mode_ff, mode_in;
   ced_pkg::ced_kind_type kind_ff, kind_in;
   logic [3:0]  cnt_ff, cnt_in;
   logic [15:0] val_ff, val_in;

   logic        accept;
   logic [7:0]  c;
   logic        flush_do, flush_utf, tail_do;
   logic [15:0] flush_val, digit_next;
   logic [7:0]  tail_byte;
   logic [3:0]  cnt_inc;
   logic [1:0]  fn;
   logic [2:0]  total;
   ced_pkg::ced_hex_type hd;
   ced_pkg::ced_enc_type enc;

   assign req_chan.ready = !q_status.full;
   assign accept         = req_chan.valid && req_chan.ready;
   assign c              = req_chan.in_byte;

   always_comb begin
      mode_in    = mode_ff;
      kind_in    = kind_ff;
      cnt_in     = cnt_ff;
      val_in     = val_ff;
      flush_do   = 1'b0;
      flush_utf  = 1'b0;
      flush_val  = val_ff;
      tail_do    = 1'b0;
      tail_byte  = c;
      hd         = ced_pkg::hex_digit(c);
      cnt_inc    = cnt_ff + 4'd1;
      digit_next = '0;
      unique case (mode_ff)
         ced_pkg::MODE_NORMAL: begin
            if (c == ced_pkg::CH_BSLASH) mode_in = ced_pkg::MODE_ESCAPE;
            else tail_do = 1'b1;
         end
         ced_pkg::MODE_ESCAPE: begin
            mode_in = ced_pkg::MODE_NORMAL;
            if (c == ced_pkg::CH_NEWLINE) begin
               // line continuation
            end else if (c == ced_pkg::CH_LOW_X || c == ced_pkg::CH_LOW_U ||
                         c == ced_pkg::CH_UP_U) begin
               mode_in = ced_pkg::MODE_HEX;
               kind_in = (c == ced_pkg::CH_LOW_X) ? ced_pkg::KIND_X :
                         (c == ced_pkg::CH_LOW_U) ? ced_pkg::KIND_U4 : ced_pkg::KIND_U8;
               cnt_in  = 4'd0;
               val_in  = 16'd0;
            end else if (c >= ced_pkg::CH_ZERO && c <= ced_pkg::CH_SEVEN) begin
               mode_in = ced_pkg::MODE_OCT;
               cnt_in  = 4'd1;
               val_in  = {13'd0, c[2:0]};
            end else begin
               tail_do   = 1'b1;
               tail_byte = ced_pkg::map_control(c);
            end
         end
         ced_pkg::MODE_HEX: begin
            flush_utf = (kind_ff != ced_pkg::KIND_X);
            if (hd.ok) begin
               digit_next = {val_ff[11:0], hd.value};
               if (cnt_inc >= ced_pkg::hex_limit(kind_ff)) begin
                  flush_do  = 1'b1;
                  flush_val = digit_next;
                  mode_in   = ced_pkg::MODE_NORMAL;
                  cnt_in    = 4'd0;
                  val_in    = 16'd0;
               end else begin
                  cnt_in = cnt_inc;
                  val_in = digit_next;
               end
            end else begin
               flush_do = 1'b1;
               cnt_in   = 4'd0;
               val_in   = 16'd0;
               if (c == ced_pkg::CH_BSLASH) mode_in = ced_pkg::MODE_ESCAPE;
               else begin
                  mode_in = ced_pkg::MODE_NORMAL;
                  tail_do = 1'b1;
               end
            end
         end
         ced_pkg::MODE_OCT: begin
            if (c >= ced_pkg::CH_ZERO && c <= ced_pkg::CH_SEVEN) begin
               digit_next = {val_ff[12:0], c[2:0]};
               if (cnt_inc >= ced_pkg::OCT_LIMIT) begin
                  flush_do  = 1'b1;
                  flush_val = digit_next;
                  mode_in   = ced_pkg::MODE_NORMAL;
                  cnt_in    = 4'd0;
                  val_in    = 16'd0;
               end else begin
                  cnt_in = cnt_inc;
                  val_in = digit_next;
               end
            end else begin
               flush_do = 1'b1;
               cnt_in   = 4'd0;
               val_in   = 16'd0;
               if (c == ced_pkg::CH_BSLASH) mode_in = ced_pkg::MODE_ESCAPE;
               else begin
                  mode_in = ced_pkg::MODE_NORMAL;
                  tail_do = 1'b1;
               end
            end
         end
         default: mode_in = ced_pkg::MODE_NORMAL;
      endcase

      // end of text: send a pending run, drop a lone backslash
      if (req_chan.end_of_text) begin
         if (mode_in == ced_pkg::MODE_HEX || mode_in == ced_pkg::MODE_OCT) begin
            flush_do  = 1'b1;
            flush_val = val_in;
            flush_utf = (mode_in == ced_pkg::MODE_HEX) && (kind_in != ced_pkg::KIND_X);
         end
         mode_in = ced_pkg::MODE_NORMAL;
         kind_in = ced_pkg::KIND_X;
         cnt_in  = 4'd0;
         val_in  = 16'd0;
      end

      if (flush_utf) enc = ced_pkg::utf8_encode(flush_val);
      else begin
         enc.data    = {16'd0, flush_val[7:0]};
         enc.count   = 2'd1;
      end
      fn    = flush_do ? enc.count : 2'd0;
      total = {1'b0, fn} + {2'd0, tail_do};

      push_data.data[0]  = (fn > 2'd0) ? enc.data[0] : tail_byte;
      push_data.data[1]  = (fn > 2'd1) ? enc.data[1] : tail_byte;
      push_data.data[2]  = (fn > 2'd2) ? enc.data[2] : tail_byte;
      push_data.data[3]  = tail_byte;
      push_data.marker   = (total == 3'd0);
      push_data.last_idx = (total == 3'd0) ? 2'd0 : 2'(total - 3'd1);
      push_data.text_end = req_chan.end_of_text;
      push = accept && ((total != 3'd0) || req_chan.end_of_text);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= ced_pkg::MODE_NORMAL;
         kind_ff <= ced_pkg::KIND_X;
         cnt_ff  <= 4'd0;
         val_ff  <= 16'd0;
      end else if (accept) begin
         mode_ff <= mode_in;
         kind_ff <= kind_in;
         cnt_ff  <= cnt_in;
         val_ff  <= val_in;
      end
   end

endmodule

@@ rtl/core/ced_queue.sv @@
// short bundle queue between front and back
`timescale 1ns / 1ps

module ced_queue (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      push,
   input  ced_pkg::ced_bundle_type   push_data,
   input  logic                      pop,
   output ced_pkg::ced_q_status_type q_status,
   output ced_pkg::ced_bundle_type   q_data
);

   ced_pkg::ced_bundle_type mem_ff [ced_pkg::QUEUE_DEPTH];
   logic [ced_pkg::QPTR_W-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [ced_pkg::QCNT_W-1:0] count_ff, count_in;

   assign q_status.not_empty = (count_ff != '0);
   assign q_status.full      = (count_ff == ced_pkg::QCNT_W'(ced_pkg::QUEUE_DEPTH));
   assign q_data             = mem_ff[rd_ptr_ff];

   always_comb begin
      count_in = count_ff;
      if (push && !pop) count_in = count_ff + ced_pkg::QCNT_W'(1);
      else if (pop && !push) count_in = count_ff - ced_pkg::QCNT_W'(1);
   end

   always_ff @(posedge clock) begin
      if (push) mem_ff[wr_ptr_ff] <= push_data;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) wr_ptr_ff <= wr_ptr_ff + ced_pkg::QPTR_W'(1);
         if (pop) rd_ptr_ff <= rd_ptr_ff + ced_pkg::QPTR_W'(1);
         count_ff <= count_in;
      end
   end

endmodule

@@ rtl/core/ced_back.sv @@
// back end: serializes bundles onto the result channel
`timescale 1ns / 1ps

module ced_back (
   input  logic                      clock,
   input  logic                      reset,
   input  ced_pkg::ced_q_status_type q_status,
   input  ced_pkg::ced_bundle_type   q_data,
   output logic                      pop,
   ced_rsp_if.source                 rsp_chan
);

   ced_pkg::ced_bundle_type cur_ff, cur_in;
   logic       cur_valid_ff, cur_valid_in;
   logic [1:0] idx_ff, idx_in;
   logic       out_valid_ff, out_valid_in;
   logic [7:0] out_byte_ff, out_byte_in;
   logic       out_bvalid_ff, out_bvalid_in;
   logic       out_last_ff, out_last_in;
   logic       out_done_ff, out_done_in;
   logic       out_free, emit, at_end;

   assign out_free = !out_valid_ff || rsp_chan.ready;
   assign emit     = cur_valid_ff && out_free;
   assign at_end   = (idx_ff == cur_ff.last_idx);

   always_comb begin
      cur_in        = cur_ff;
      cur_valid_in  = cur_valid_ff;
      idx_in        = idx_ff;
      pop           = 1'b0;
      out_valid_in  = out_valid_ff && !rsp_chan.ready;
      out_byte_in   = out_byte_ff;
      out_bvalid_in = out_bvalid_ff;
      out_last_in   = out_last_ff;
      out_done_in   = out_done_ff;
      if (emit) begin
         out_valid_in  = 1'b1;
         out_byte_in   = cur_ff.marker ? 8'd0 : cur_ff.data[idx_ff];
         out_bvalid_in = !cur_ff.marker;
         out_last_in   = at_end;
         out_done_in   = at_end && cur_ff.text_end;
      end
      if (!cur_valid_ff || (emit && at_end)) begin
         pop          = q_status.not_empty;
         cur_valid_in = q_status.not_empty;
         cur_in       = q_data;
         idx_in       = 2'd0;
      end else if (emit) begin
         idx_in = idx_ff + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff        <= cur_in;
      out_byte_ff   <= out_byte_in;
      out_bvalid_ff <= out_bvalid_in;
      out_last_ff   <= out_last_in;
      out_done_ff   <= out_done_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_valid_ff <= 1'b0;
         idx_ff       <= 2'd0;
         out_valid_ff <= 1'b0;
      end else begin
         cur_valid_ff <= cur_valid_in;
         idx_ff       <= idx_in;
         out_valid_ff <= out_valid_in;
      end
   end

   assign rsp_chan.valid      = out_valid_ff;
   assign rsp_chan.out_byte   = out_byte_ff;
   assign rsp_chan.byte_valid = out_bvalid_ff;
   assign rsp_chan.run_last   = out_last_ff;
   assign rsp_chan.text_done  = out_done_ff;

endmodule

@@ rtl/core/c_escape_sequence_decoder.sv @@
// top level of the c escape sequence decoder
`timescale 1ns / 1ps

// usage
//   req_chan carries one source byte per beat plus end_of_text on the last byte
//   rsp_chan carries decoded bytes; run_last marks the last byte caused by one
//   request beat, text_done the last byte of the whole text
//   a text whose last beat yields no byte ends with one beat with byte_valid 0
// timing
//   the front end takes a request beat every cycle while the queue has room
//   and turns it into a bundle of 0 to 4 bytes in the same cycle, which then
//   passes the bundle queue, the current-bundle register and the result
//   register; the back end sends one result beat per cycle while rsp ready
//   is high, so sustained request rate is one beat per cycle for plain text
//   and lower for multi-byte beats; the four-entry queue absorbs short bursts
// reset
//   synchronous, active high; escape state returns to plain text, queue and
//   result register empty
// stall
//   rsp ready low holds the result register; the back end then stops draining,
//   the queue fills and req ready drops once it holds four bundles

module c_escape_sequence_decoder (
   input  logic       clock,
   input  logic       reset,
   ced_req_if.sink    req_chan,
   ced_rsp_if.source  rsp_chan
);

   // front to queue
   logic                      push;
   ced_pkg::ced_bundle_type   push_data;
   // queue to back
   ced_pkg::ced_q_status_type q_status;
   ced_pkg::ced_bundle_type   q_data;
   logic                      pop;

   // escape decoding, at most one bundle per request beat
   ced_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan),
      .q_status  (q_status),
      .push      (push),
      .push_data (push_data)
   );

   // decouples decode from the result stall
   ced_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .pop       (pop),
      .q_status  (q_status),
      .q_data    (q_data)
   );

   // one byte per result beat through a registered output
   ced_back u_back (
      .clock    (clock),
      .reset    (reset),
      .q_status (q_status),
      .q_data   (q_data),
      .pop      (pop),
      .rsp_chan (rsp_chan)
   );

endmodule

@@ rtl/core/ced_checker.sv @@
// port-level checks on the escape decoder and their bind
`timescale 1ns / 1ps

module ced_checker (
   input logic       clock,
   input logic       reset,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [7:0] rsp_out_byte,
   input logic       rsp_byte_valid,
   input logic       rsp_run_last,
   input logic       rsp_text_done
);

   // result register comes out of reset empty
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");

   // a stalled beat holds
   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_out_byte) &&
      $stable(rsp_byte_valid) && $stable(rsp_run_last) && $stable(rsp_text_done))
      else $error("stalled result changed");

   // end of text always closes a run
   a_done_is_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_text_done |-> rsp_run_last)
      else $error("text_done without run_last");

   // the empty marker only closes a text and carries zero
   a_marker_form: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_byte_valid |-> rsp_text_done && rsp_out_byte == 8'd0)
      else $error("bad empty end marker");

endmodule

bind c_escape_sequence_decoder ced_checker u_ced_checker (
   .clock          (clock),
   .reset          (reset),
   .rsp_valid      (rsp_chan.valid),
   .rsp_ready      (rsp_chan.ready),
   .rsp_out_byte   (rsp_chan.out_byte),
   .rsp_byte_valid (rsp_chan.byte_valid),
   .rsp_run_last   (rsp_chan.run_last),
   .rsp_text_done  (rsp_chan.text_done)
);

@@ dv/tb.sv @@
// testbench for the c escape sequence decoder: directed table, random text, self-checking
`timescale 1ns / 1ps

module tb;

   // one decoded byte as it leaves the result channel
   typedef struct packed {
      logic [7:0] out_byte;
      logic       byte_valid;
      logic       run_last;
      logic       text_done;
   } decoded_beat_type;

   // one source byte; want/nwant hold a typed-in answer when typed is set
   typedef struct packed {
      logic [7:0]      text_byte;
      logic            eot;
      logic            typed;
      logic [2:0]      nwant;
      logic [3:0][7:0] want;
   } text_row_type;

   localparam int STALL_LIMIT = 2000;   // cycles with no beat on either channel
   localparam int LONG_HOLD   = 300;    // receiver hold-off used to back up the queue
   localparam int PHASE_ITEMS = 38;     // least number of random source bytes per idling phase
   localparam int TAIL_CYCLES = 20;     // settle time once nothing is outstanding

   // directed text: plain bytes, controls, line continuation, every escape form,
   // full runs, surrogate, empty hex run, octal cut to 8 bits, trailing backslash
   localparam text_row_type DIRECTED [25] = '{
      '{8'h41,    1'b0, 1'b1, 3'd1, 32'h0000_0041},   // plain 'A'
      '{8'hFF,    1'b0, 1'b1, 3'd1, 32'h0000_00FF},   // top byte passes
      '{8'h00,    1'b0, 1'b1, 3'd1, 32'h0000_0000},   // bottom byte passes
      '{ced_pkg::CH_BSLASH, 1'b0, 1'b1, 3'd0, 32'h0},
      '{"a",      1'b0, 1'b1, 3'd1, 32'h0000_0007},   // bell
      '{ced_pkg::CH_BSLASH, 1'b0, 1'b1, 3'd0, 32'h0},
      '{ced_pkg::CH_NEWLINE, 1'b0, 1'b1, 3'd0, 32'h0},   // line continuation dropped
      '{ced_pkg::CH_BSLASH, 1'b0, 1'b0, 3'd0, 32'h0},
      '{"x",      1'b0, 1'b0, 3'd0, 32'h0},
      '{"F",      1'b0, 1'b0, 3'd0, 32'h0},
      '{"f",      1'b0, 1'b1, 3'd1, 32'h0000_00FF},   // two digits fill the run
      '{ced_pkg::CH_BSLASH, 1'b0, 1'b0, 3'd0, 32'h0},
      '{"u",      1'b0, 1'b0, 3'd0, 32'h0},
      '{"D",      1'b0, 1'b0, 3'd0, 32'h0},
      '{"8",      1'b0, 1'b0, 3'd0, 32'h0},
      '{"0",      1'b0, 1'b0, 3'd0, 32'h0},
      '{"0",      1'b0, 1'b1, 3'd1, 32'h0000_003F},   // surrogate gives '?'
      '{ced_pkg::CH_BSLASH, 1'b0, 1'b0, 3'd0, 32'h0},
      '{"U",      1'b0, 1'b0, 3'd0, 32'h0},
      '{"g",      1'b0, 1'b1, 3'd2, 32'h0000_6700},   // empty run gives 00, then 'g'
      '{ced_pkg::CH_BSLASH, 1'b0, 1'b0, 3'd0, 32'h0},
      '{"7",      1'b0, 1'b0, 3'd0, 32'h0},
      '{"7",      1'b0, 1'b0, 3'd0, 32'h0},
      '{"7",      1'b0, 1'b1, 3'd1, 32'h0000_00FF},   // 0o777 cut to 8 bits
      '{ced_pkg::CH_BSLASH, 1'b1, 1'b1, 3'd0, 32'h0}   // lone backslash at end: marker
   };

   logic clock;
   logic reset;

   ced_req_if req_chan ();
   ced_rsp_if rsp_chan ();

   c_escape_sequence_decoder uut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   // decoder state mirrored by the testbench
   ced_pkg::ced_mode_type dec_mode;
   ced_pkg::ced_kind_type dec_kind;
   logic [3:0]            dec_count;
   logic [15:0]           dec_value;
   logic [3:0][7:0]       step_bytes;
   int                    step_n;

   decoded_beat_type due_beats [$];    // decoded bytes still owed by the block
   text_row_type     seg_q [$];        // source bytes of the segment being built

   int fail_count;
   int mismatch_count;
   int send_idle_pct;
   int recv_stall_pct;
   int hold_seq;

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // ---------------------------------------------------------------- predictor

   function automatic void emit_byte(input logic [7:0] b);
      if (step_n < 4) begin
         step_bytes[step_n] = b;
         step_n++;
      end
   endfunction

   function automatic int hex_nibble(input logic [7:0] c);
      if (c >= "0" && c <= "9") return int'(c - "0");
      if (c >= "a" && c <= "f") return int'(c - "a") + 10;
      if (c >= "A" && c <= "F") return int'(c - "A") + 10;
      return -1;
   endfunction

   function automatic int kind_digits(input ced_pkg::ced_kind_type k);
      case (k)
         ced_pkg::KIND_U4: return 4;
         ced_pkg::KIND_U8: return 8;
         default:          return 2;
      endcase
   endfunction

   function automatic logic [7:0] control_code(input logic [7:0] c);
      case (c)
         "a":     return 8'h07;
         "b":     return 8'h08;
         "f":     return 8'h0C;
         "n":     return 8'h0A;
         "r":     return 8'h0D;
         "t":     return 8'h09;
         "v":     return 8'h0B;
         default: return c;
      endcase
   endfunction

   // send the collected digits: \x and octal as one byte, \u and \U as utf-8
   function automatic void flush_digits();
      logic [15:0] v;
      v = dec_value;
      if (dec_mode == ced_pkg::MODE_HEX && dec_kind != ced_pkg::KIND_X) begin
         if (v < 16'h0080) begin
            emit_byte(v[7:0]);
         end else if (v < 16'h0800) begin
            emit_byte(8'hC0 | {3'b000, v[10:6]});
            emit_byte(8'h80 | {2'b00, v[5:0]});
         end else if (v >= 16'hD800 && v <= 16'hDFFF) begin
            emit_byte(ced_pkg::CH_QUESTION);
         end else begin
            emit_byte(8'hE0 | {4'h0, v[15:12]});
            emit_byte(8'h80 | {2'b00, v[11:6]});
            emit_byte(8'h80 | {2'b00, v[5:0]});
         end
      end else begin
         emit_byte(v[7:0]);
      end
      dec_mode  = ced_pkg::MODE_NORMAL;
      dec_count = 4'd0;
      dec_value = 16'd0;
   endfunction

   function automatic void plain_byte(input logic [7:0] c);
      if (c == ced_pkg::CH_BSLASH) dec_mode = ced_pkg::MODE_ESCAPE;
      else emit_byte(c);
   endfunction

   // advance the mirrored state by one source byte, bytes land in step_bytes
   function automatic void decode_byte(input logic [7:0] c, input logic eot);
      int d;
      step_n     = 0;
      step_bytes = '0;
      case (dec_mode)
         ced_pkg::MODE_NORMAL: plain_byte(c);
         ced_pkg::MODE_ESCAPE: begin
            dec_mode = ced_pkg::MODE_NORMAL;
            if (c == ced_pkg::CH_LOW_X || c == ced_pkg::CH_LOW_U ||
                c == ced_pkg::CH_UP_U) begin
               dec_mode  = ced_pkg::MODE_HEX;
               dec_kind  = (c == ced_pkg::CH_LOW_X) ? ced_pkg::KIND_X :
                           (c == ced_pkg::CH_LOW_U) ? ced_pkg::KIND_U4 : ced_pkg::KIND_U8;
               dec_count = 4'd0;
               dec_value = 16'd0;
            end else if (c >= ced_pkg::CH_ZERO && c <= ced_pkg::CH_SEVEN) begin
               dec_mode  = ced_pkg::MODE_OCT;
               dec_count = 4'd1;
               dec_value = {13'd0, c[2:0]};
            end else if (c != ced_pkg::CH_NEWLINE) begin
               emit_byte(control_code(c));
            end
         end
         ced_pkg::MODE_HEX: begin
            d = hex_nibble(c);
            if (d < 0) begin
               flush_digits();
               plain_byte(c);
            end else begin
               dec_value = {dec_value[11:0], d[3:0]};
               dec_count = dec_count + 4'd1;
               if (int'(dec_count) >= kind_digits(dec_kind)) flush_digits();
            end
         end
         default: begin
            if (c >= ced_pkg::CH_ZERO && c <= ced_pkg::CH_SEVEN) begin
               dec_value = {dec_value[12:0], c[2:0]};
               dec_count = dec_count + 4'd1;
               if (dec_count >= ced_pkg::OCT_LIMIT) flush_digits();
            end else begin
               flush_digits();
               plain_byte(c);
            end
         end
      endcase
      if (eot) begin
         if (dec_mode == ced_pkg::MODE_HEX || dec_mode == ced_pkg::MODE_OCT) flush_digits();
         dec_mode  = ced_pkg::MODE_NORMAL;
         dec_kind  = ced_pkg::KIND_X;
         dec_count = 4'd0;
         dec_value = 16'd0;
      end
   endfunction

   function automatic void queue_beats(input logic [3:0][7:0] bytes, input int n,
                                       input logic eot);
      decoded_beat_type b;
      if (n == 0) begin
         // a text whose last byte yields nothing still closes with a marker beat
         if (eot) begin
            b = '{out_byte: 8'h00, byte_valid: 1'b0, run_last: 1'b1, text_done: 1'b1};
            due_beats.insert(due_beats.size(), b);
         end
      end else begin
         for (int k = 0; k < n; k++) begin
            b.out_byte   = bytes[k];
            b.byte_valid = 1'b1;
            b.run_last   = (k == n - 1);
            b.text_done  = (k == n - 1) && eot;
            due_beats.insert(due_beats.size(), b);
         end
      end
   endfunction

   // called on every accepted source byte
   function automatic void predict_item(input text_row_type r);
      decode_byte(r.text_byte, r.eot);
      if (r.typed) queue_beats(r.want, int'(r.nwant), r.eot);
      else queue_beats(step_bytes, step_n, r.eot);
   endfunction

   // ------------------------------------------------------------------ sender

   // offer one byte, idling beforehand at the phase rate, and wait for the beat
   task automatic send_item(input text_row_type r);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_chan.valid <= 1'b0;
         @(posedge clock);
      end
      req_chan.valid       <= 1'b1;
      req_chan.in_byte     <= r.text_byte;
      req_chan.end_of_text <= r.eot;
      do @(posedge clock); while (!req_chan.ready);
      predict_item(r);
   endtask

   task automatic wait_drained();
      req_chan.valid <= 1'b0;
      @(posedge clock);
      while (due_beats.size() != 0) @(posedge clock);
   endtask

   // ---------------------------------------------------------- text generator

   function automatic void seg_add(input logic [7:0] c);
      text_row_type r;
      r           = '0;
      r.text_byte = c;
      seg_q.insert(seg_q.size(), r);
   endfunction

   function automatic logic [7:0] hex_char(input logic [3:0] n);
      if (n < 4'd10) return ced_pkg::CH_ZERO + {4'h0, n};
      if ($urandom_range(0, 1)) return ced_pkg::CH_LOW_A + {4'h0, n} - 8'd10;
      return ced_pkg::CH_UP_A + {4'h0, n} - 8'd10;
   endfunction

   // code point from one utf-8 length class, surrogates included
   function automatic logic [15:0] pick_code_point();
      case ($urandom_range(0, 3))
         0:       return 16'($urandom_range(0, 16'h007F));
         1:       return 16'($urandom_range(16'h0080, 16'h07FF));
         2:       return 16'($urandom_range(16'hD800, 16'hDFFF));
         default: return 16'($urandom_range(16'h0800, 16'hFFFF));
      endcase
   endfunction

   function automatic logic [7:0] control_code_char(input int idx);
      case (idx)
         0:       return "a";
         1:       return "b";
         2:       return "f";
         3:       return "n";
         4:       return "r";
         5:       return "t";
         default: return "v";
      endcase
   endfunction

   // build one random piece of text: mostly well formed escapes with random
   // digits and lengths, some broken ones, and raw bytes of any value
   function automatic void build_segment();
      logic [31:0] digits;
      int          ndig;
      int          nplain;
      seg_q.delete();
      case ($urandom_range(0, 9))
         0, 1: begin
            nplain = $urandom_range(1, 3);
            for (int k = 0; k < nplain; k++) seg_add(8'($urandom_range(0, 255)));
         end
         2: begin
            seg_add(ced_pkg::CH_BSLASH);
            if ($urandom_range(0, 3) == 0) seg_add(8'($urandom_range(0, 255)));
            else seg_add(control_code_char($urandom_range(0, 6)));
         end
         3: begin
            seg_add(ced_pkg::CH_BSLASH);
            seg_add(ced_pkg::CH_NEWLINE);
         end
         4: begin
            seg_add(ced_pkg::CH_BSLASH);
            seg_add(ced_pkg::CH_LOW_X);
            digits = $urandom;
            ndig   = $urandom_range(0, 3);
            for (int k = 0; k < ndig; k++) seg_add(hex_char(digits[31 - 4*k -: 4]));
         end
         5: begin
            seg_add(ced_pkg::CH_BSLASH);
            seg_add(ced_pkg::CH_LOW_U);
            digits = {pick_code_point(), 16'($urandom)};
            ndig   = $urandom_range(0, 5);
            for (int k = 0; k < ndig; k++) seg_add(hex_char(digits[31 - 4*k -: 4]));
         end
         6: begin
            // only the low four of eight digits survive the 16-bit cut
            seg_add(ced_pkg::CH_BSLASH);
            seg_add(ced_pkg::CH_UP_U);
            digits = {16'($urandom), pick_code_point()};
            ndig   = $urandom_range(0, 9);
            for (int k = 0; k < ndig; k++) begin
               if (k < 8) seg_add(hex_char(digits[31 - 4*k -: 4]));
               else seg_add(hex_char(4'($urandom)));
            end
         end
         7: begin
            seg_add(ced_pkg::CH_BSLASH);
            ndig = $urandom_range(1, 4);
            for (int k = 0; k < ndig; k++)
               seg_add(ced_pkg::CH_ZERO + 8'($urandom_range(0, 7)));
            if ($urandom_range(0, 2) == 0) seg_add("8");
         end
         8: seg_add(ced_pkg::CH_BSLASH);   // broken escape, whatever follows completes it
         default: seg_add(8'($urandom_range(8'h80, 8'hFF)));
      endcase
      // some segments close the text, cutting whatever escape is open
      if ($urandom_range(0, 5) == 0) seg_q[seg_q.size() - 1].eot = 1'b1;
   endfunction

   // ---------------------------------------------------------------- receiver

   function automatic void check_beat();
      decoded_beat_type got;
      decoded_beat_type want;
      got.out_byte   = rsp_chan.out_byte;
      got.byte_valid = rsp_chan.byte_valid;
      got.run_last   = rsp_chan.run_last;
      got.text_done  = rsp_chan.text_done;
      if (due_beats.size() == 0) begin
         fail_count++;
         mismatch_count++;
         if (mismatch_count <= 10)
            $display("unexpected beat: byte %02h valid %0b run_last %0b done %0b",
                     got.out_byte, got.byte_valid, got.run_last, got.text_done);
         return;
      end
      want = due_beats.pop_front();
      if (got !== want) begin
         fail_count++;
         mismatch_count++;
         if (mismatch_count <= 10)
            $display("mismatch: want %02h/%0b/%0b/%0b got %02h/%0b/%0b/%0b",
                     want.out_byte, want.byte_valid, want.run_last, want.text_done,
                     got.out_byte, got.byte_valid, got.run_last, got.text_done);
      end
   endfunction

   // result side: checks each beat, stalls at the phase rate, and runs the
   // long hold-off whenever the main flow bumps hold_seq
   initial begin
      int hold_seen;
      int hold_left;
      hold_seen = 0;
      hold_left = 0;
      rsp_chan.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_chan.valid && rsp_chan.ready) check_beat();
         if (hold_seq != hold_seen) begin
            hold_seen = hold_seq;
            hold_left = LONG_HOLD;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_chan.ready <= 1'b0;
         end else begin
            rsp_chan.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
         end
      end
   end

   // ---------------------------------------------------------------- watchdog

   initial begin
      int quiet;
      quiet = 0;
      forever begin
         @(posedge clock);
         if ((req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready))
            quiet = 0;
         else
            quiet++;
         if (quiet >= STALL_LIMIT) begin
            $display("TB_ERROR");
            $finish;
         end
      end
   end

   // -------------------------------------------------------------- main flow

   initial begin
      int phase_items;
      fail_count     = 0;
      mismatch_count = 0;
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      hold_seq       = 0;
      dec_mode       = ced_pkg::MODE_NORMAL;
      dec_kind       = ced_pkg::KIND_X;
      dec_count      = 4'd0;
      dec_value      = 16'd0;

      reset                <= 1'b1;
      req_chan.valid       <= 1'b0;
      req_chan.in_byte     <= 8'h00;
      req_chan.end_of_text <= 1'b0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed table at full rate
      foreach (DIRECTED[i]) send_item(DIRECTED[i]);
      wait_drained();

      // random text over four idling phases; each phase ends with the sender
      // paused until every owed byte has come back
      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 54; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 54; end
            default: begin send_idle_pct = 22; recv_stall_pct = 22; end
         endcase
         // first phase: receiver holds off while bytes keep coming, so the
         // bundle queue fills and request ready has to drop
         if (phase == 0) hold_seq = hold_seq + 1;
         phase_items = 0;
         while (phase_items < PHASE_ITEMS) begin
            build_segment();
            foreach (seg_q[k]) send_item(seg_q[k]);
            phase_items += seg_q.size();
         end
         wait_drained();
      end

      // close the last text so the block ends in plain mode
      send_item('{text_byte: 8'h2E, eot: 1'b1, typed: 1'b0, nwant: 3'd0, want: 32'h0});
      wait_drained();
      repeat (TAIL_CYCLES) @(posedge clock);

      if (fail_count == 0 && due_beats.size() == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

endmodule
